FILE: src/set_assoc_cache_lru_lookup_core_assert.svh
// assertion macros for the set-associative lru lookup core
// used by the checker; expects clk and rst in the including scope
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_CORE_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_CORE_ASSERT_SVH

// same-cycle implication
`define SACL_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sacl assertion failed");

// next-cycle implication
`define SACL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sacl assertion failed");

`endif

FILE: src/sacl_pkg.sv
// shared constants for the set-associative lru lookup core
// no dependencies
`default_nettype none

package sacl_pkg;

  localparam int ADDR_W = 32;
  localparam int TIME_W = 32;

  localparam logic FUNC_WRITE = 1'b1;

endpackage

`default_nettype wire

FILE: src/set_assoc_cache_lru_lookup_core.sv
// result: through the lookup then the output registers; later while out_stall holds the last
// accesses do not overlap: a new one waits for the read then write-back of the set memory
// reset: synchronous; a clearing pass then zeroes one set row per cycle over all
// 2**floor(log2(SETS)) rows (64 at the defaults) with in_stall held high
// depends on sacl_pkg
`default_nettype none

module set_assoc_cache_lru_lookup_core
  import sacl_pkg::*;
#(
  parameter int SETS       = 64,
  parameter int WAYS       = 4,
  parameter int LINE_BYTES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              func,
  input  wire logic [ADDR_W-1:0] address,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   hit,
  output logic                   evicted,
  output logic                   writeback,
  output logic [ADDR_W-1:0]      victim_block_addr
);

  localparam int OB     = $clog2(LINE_BYTES + 1) - 1;
  localparam int IB     = $clog2(SETS + 1) - 1;
  localparam int TAG_W  = ADDR_W - IB - OB;
  localparam int ROWS   = 1 << IB;
  localparam int SET_AW = (IB > 0) ? IB : 1;
  localparam int WAY_AW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LEAVES = 1 << $clog2(WAYS);

  typedef struct packed {
    logic              valid;
    logic              dirty;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] stamp;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  row_t mem [ROWS];

  logic              in_accept;
  logic [SET_AW-1:0] in_set;
  logic [TAG_W-1:0]  in_tag;

  logic              lk_valid;
  logic              lk_func;
  logic [TAG_W-1:0]  lk_tag;
  logic [SET_AW-1:0] lk_set;
  row_t              rd_row;
  logic              lk_done;

  logic              clr_active;
  logic [SET_AW-1:0] clr_addr;

  logic [TIME_W-1:0] access_clock;
  logic [TIME_W-1:0] stamp_next;

  logic              hit_any;
  logic [WAY_AW-1:0] hit_way;
  logic              inv_any;
  logic [WAY_AW-1:0] inv_way;
  logic [WAY_AW-1:0] lru_way;
  logic [WAY_AW-1:0] sel_way;
  logic              miss_evict;
  way_t              vic;
  row_t              new_row;
  logic [ADDR_W-1:0] vic_addr;

  logic [TIME_W-1:0] nt [2*LEAVES];
  logic [WAY_AW-1:0] ni [2*LEAVES];
  logic              np [2*LEAVES];

  logic              mem_we;
  logic [SET_AW-1:0] mem_waddr;
  row_t              mem_wdata;

  assign in_stall  = clr_active || lk_valid;
  assign in_accept = in_valid && !in_stall;
  assign in_set    = SET_AW'((address >> OB) & ADDR_W'(ROWS - 1));
  assign in_tag    = TAG_W'(address >> (IB + OB));
  assign lk_done   = lk_valid && (!out_valid || !out_stall);
  assign stamp_next = access_clock + TIME_W'(1);

  // hit and first invalid way, lowest index first
  always_comb begin
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit_any && rd_row[w].valid && rd_row[w].tag == lk_tag) begin
        hit_any = 1'b1;
        hit_way = WAY_AW'(w);
      end
      if (!inv_any && !rd_row[w].valid) begin
        inv_any = 1'b1;
        inv_way = WAY_AW'(w);
      end
    end
  end

  // lru tree, ties go to the higher way
  always_comb begin
    for (int n = 0; n < 2*LEAVES; n++) begin
      nt[n] = '1;
      ni[n] = '0;
      np[n] = 1'b1;
    end
    for (int l = 0; l < LEAVES; l++) begin
      if (l < WAYS) begin
        nt[LEAVES+l] = rd_row[l].stamp;
        ni[LEAVES+l] = WAY_AW'(l);
        np[LEAVES+l] = 1'b0;
      end
    end
    for (int i = LEAVES - 1; i >= 1; i--) begin
      if (!np[2*i+1] && nt[2*i+1] <= nt[2*i]) begin
        nt[i] = nt[2*i+1];
        ni[i] = ni[2*i+1];
        np[i] = 1'b0;
      end else begin
        nt[i] = nt[2*i];
        ni[i] = ni[2*i];
        np[i] = np[2*i];
      end
    end
    lru_way = ni[1];
  end

  assign miss_evict = !hit_any && !inv_any;
  assign sel_way    = hit_any ? hit_way : (inv_any ? inv_way : lru_way);
  assign vic        = rd_row[lru_way];
  assign vic_addr   = miss_evict ?
                      ((ADDR_W'(vic.tag) << (IB + OB)) | (ADDR_W'(lk_set) << OB)) : '0;

  always_comb begin
    new_row = rd_row;
    if (hit_any) begin
      new_row[sel_way].stamp = stamp_next;
      new_row[sel_way].dirty = rd_row[sel_way].dirty || (lk_func == FUNC_WRITE);
    end else begin
      new_row[sel_way].valid = 1'b1;
      new_row[sel_way].dirty = (lk_func == FUNC_WRITE);
      new_row[sel_way].tag   = lk_tag;
      new_row[sel_way].stamp = stamp_next;
    end
  end

  assign mem_we    = clr_active || lk_done;
  assign mem_waddr = clr_active ? clr_addr : lk_set;
  assign mem_wdata = clr_active ? '0 : new_row;

  // set memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_row <= mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == SET_AW'(ROWS - 1)) begin
        clr_active <= 1'b0;
      end
      clr_addr <= clr_addr + SET_AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lk_valid     <= 1'b0;
      out_valid    <= 1'b0;
      access_clock <= '0;
    end else begin
      if (in_accept) begin
        lk_valid <= 1'b1;
      end else if (lk_done) begin
        lk_valid <= 1'b0;
      end
      if (lk_done) begin
        out_valid    <= 1'b1;
        access_clock <= stamp_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      lk_func <= func;
      lk_tag  <= in_tag;
      lk_set  <= in_set;
    end
    if (lk_done) begin
      hit               <= hit_any;
      evicted           <= miss_evict;
      writeback         <= miss_evict && vic.dirty;
      victim_block_addr <= vic_addr;
    end
  end

endmodule

`default_nettype wire

FILE: src/sacl_checker.sv
// port-level checker for the set-associative lru lookup core, with its bind
// depends on sacl_pkg and set_assoc_cache_lru_lookup_core_assert.svh
`default_nettype none

`include "set_assoc_cache_lru_lookup_core_assert.svh"

module sacl_checker
  import sacl_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              hit,
  input wire logic              evicted,
  input wire logic              writeback,
  input wire logic [ADDR_W-1:0] victim_block_addr
);

  `SACL_ASSERT_IMPLIES(a_hit_no_evict, out_valid && hit, !evicted)
  `SACL_ASSERT_IMPLIES(a_wb_needs_evict, out_valid && writeback, evicted)
  `SACL_ASSERT_IMPLIES(a_no_evict_zero_addr, out_valid && !evicted, victim_block_addr == '0)
  `SACL_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)

endmodule

bind set_assoc_cache_lru_lookup_core sacl_checker u_sacl_checker (.*);

`default_nettype wire

FILE: test/tb_set_assoc_cache_lru_lookup_core.sv
// testbench for set_assoc_cache_lru_lookup_core: directed and random read/write accesses
// checked against a tag, valid, dirty and lru-time predictor kept in the bench
// depends on sacl_pkg and the core rtl
module tb_set_assoc_cache_lru_lookup_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sacl_pkg::*;

  localparam int SETS         = 64;
  localparam int WAYS         = 4;
  localparam int LINE_BYTES   = 32;
  localparam int OFS_W        = $clog2(LINE_BYTES);
  localparam int SET_W        = $clog2(SETS);
  localparam int TAG_W        = ADDR_W - SET_W - OFS_W;
  localparam int LINES        = SETS * WAYS;
  localparam logic FUNC_READ  = 1'b0;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic              writeback;
    logic [ADDR_W-1:0] victim;
  } lookup_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              func = FUNC_READ;
  logic [ADDR_W-1:0] address = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              hit;
  logic              evicted;
  logic              writeback;
  logic [ADDR_W-1:0] victim_block_addr;

  // predictor state
  logic [TAG_W-1:0]  line_tag   [LINES];
  bit                line_valid [LINES];
  bit                line_dirty [LINES];
  logic [TIME_W-1:0] line_stamp [LINES];
  logic [TIME_W-1:0] use_clock = '0;

  lookup_t           expected_q[$];
  int                error_count = 0;
  int                idle_cycles = 0;
  bit                idle_en = 1'b1;
  bit                hold_req = 1'b0;
  logic [TAG_W-1:0]  hot_tags [6];
  logic [SET_W-1:0]  hot_sets [3];

  set_assoc_cache_lru_lookup_core #(
    .SETS      (SETS),
    .WAYS      (WAYS),
    .LINE_BYTES(LINE_BYTES)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .func             (func),
    .address          (address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hit              (hit),
    .evicted          (evicted),
    .writeback        (writeback),
    .victim_block_addr(victim_block_addr)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic lookup_t lookup_and_update(input logic f, input logic [ADDR_W-1:0] a);
    lookup_t           r;
    logic [SET_W-1:0]  set_idx;
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] oldest;
    int                base;
    int                line;
    bit                found;
    bit                have_free;
    r         = '0;
    set_idx   = a[OFS_W +: SET_W];
    tag       = a[ADDR_W-1 -: TAG_W];
    base      = int'(set_idx) * WAYS;
    line      = base;
    found     = 1'b0;
    have_free = 1'b0;
    use_clock = use_clock + 1'b1;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && line_valid[base+w] && line_tag[base+w] == tag) begin
        found = 1'b1;
        line  = base + w;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      line_stamp[line] = use_clock;
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (!have_free && !line_valid[base+w]) begin
          have_free = 1'b1;
          line      = base + w;
        end
      end
      if (!have_free) begin
        // least recently used, ties go to the higher way
        oldest = '1;
        for (int w = 0; w < WAYS; w++) begin
          if (line_stamp[base+w] <= oldest) begin
            oldest = line_stamp[base+w];
            line   = base + w;
          end
        end
        r.evicted   = 1'b1;
        r.writeback = line_dirty[line];
        r.victim    = {line_tag[line], set_idx, {OFS_W{1'b0}}};
      end
      line_tag[line]   = tag;
      line_valid[line] = 1'b1;
      line_dirty[line] = 1'b0;
      line_stamp[line] = use_clock;
    end
    if (f == FUNC_WRITE) line_dirty[line] = 1'b1;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_W-1:0] tag,
                                                  input logic [SET_W-1:0] set_idx,
                                                  input logic [OFS_W-1:0] ofs);
    return {tag, set_idx, ofs};
  endfunction

  function automatic void refresh_pool();
    foreach (hot_tags[i]) hot_tags[i] = TAG_W'($urandom());
    foreach (hot_sets[i]) hot_sets[i] = SET_W'($urandom());
  endfunction

  // mostly conflicting lines in a few sets, some scattered addresses
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [OFS_W-1:0] ofs;
    ofs = OFS_W'($urandom_range(0, LINE_BYTES - 1));
    if ($urandom_range(0, 6) == 0) return $urandom();
    return line_addr(hot_tags[$urandom_range(0, 5)], hot_sets[$urandom_range(0, 2)], ofs);
  endfunction

  task automatic send_access(input logic f, input logic [ADDR_W-1:0] a);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    address  <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(lookup_and_update(f, a));
  endtask

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) $display("%t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    lookup_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result hit=%0b evicted=%0b wb=%0b victim=%h",
                                  hit, evicted, writeback, victim_block_addr));
      end else begin
        exp_r = expected_q.pop_front();
        if (hit !== exp_r.hit || evicted !== exp_r.evicted ||
            writeback !== exp_r.writeback || victim_block_addr !== exp_r.victim) begin
          report_mismatch($sformatf(
            "exp hit=%0b evicted=%0b wb=%0b victim=%h, got hit=%0b evicted=%0b wb=%0b victim=%h",
            exp_r.hit, exp_r.evicted, exp_r.writeback, exp_r.victim,
            hit, evicted, writeback, victim_block_addr));
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_set_assoc_cache_lru_lookup_core: done, errors");
      $finish;
    end
  end

  task automatic test_fill_and_hit();
    send_access(FUNC_READ, 32'h0000_0000);
    send_access(FUNC_WRITE, 32'hFFFF_FFFF);
    send_access(FUNC_READ, 32'h0000_001F);
    send_access(FUNC_WRITE, 32'h0000_0000);
    send_access(FUNC_READ, 32'hFFFF_FFE0);
  endtask

  task automatic test_set_conflict();
    logic [SET_W-1:0] top_set;
    top_set = '1;
    // fill the top set, then evict the dirty all-ones line
    send_access(FUNC_WRITE, line_addr(21'd0, top_set, 5'd0));
    send_access(FUNC_READ,  line_addr(21'd1, top_set, 5'd3));
    send_access(FUNC_WRITE, line_addr(21'd2, top_set, 5'd31));
    send_access(FUNC_READ,  line_addr(21'd3, top_set, 5'd0));
    send_access(FUNC_READ,  line_addr(21'd1, top_set, 5'd7));
    send_access(FUNC_READ,  line_addr(21'd4, top_set, 5'd0));
    send_access(FUNC_READ,  line_addr(21'd5, top_set, 5'd0));
    send_access(FUNC_WRITE, line_addr(21'd6, top_set, 5'd16));
    send_access(FUNC_READ,  line_addr(21'd7, top_set, 5'd0));
    // set zero: evicting the dirty line at address zero gives a zero victim address
    send_access(FUNC_WRITE, line_addr('1, '0, 5'd0));
    send_access(FUNC_READ,  line_addr(21'h0A_AAAA, '0, 5'd0));
    send_access(FUNC_READ,  line_addr(21'h15_5555, '0, 5'd0));
    send_access(FUNC_READ,  line_addr(21'd9, '0, 5'd0));
    send_access(FUNC_WRITE, line_addr('1, '0, 5'd31));
    send_access(FUNC_READ,  line_addr(21'd10, '0, 5'd0));
  endtask

  task automatic test_random_mix();
    for (int i = 0; i < 1200; i++) begin
      if (i % 150 == 0) refresh_pool();
      send_access(logic'($urandom_range(0, 1)), pick_address());
    end
  endtask

  task automatic test_stall_backlog();
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_access(logic'($urandom_range(0, 1)), pick_address());
  endtask

  task automatic test_streaming();
    idle_en = 1'b0;
    refresh_pool();
    for (int i = 0; i < 250; i++) send_access(logic'($urandom_range(0, 1)), pick_address());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_fill_and_hit();
    test_set_conflict();
    test_random_mix();
    test_stall_backlog();
    test_streaming();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_set_assoc_cache_lru_lookup_core: done, clean");
    end else begin
      $display("tb_set_assoc_cache_lru_lookup_core: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/sacl_pkg.sv
src/set_assoc_cache_lru_lookup_core.sv
src/sacl_checker.sv
test/tb_set_assoc_cache_lru_lookup_core.sv
